@@ hw/rtl/dsep_pkg.sv @@
// Package for the dual serial EEPROM port core.
// Holds the sizes, command codes, controller state type and the controller command struct.
// Used by dsep_ctrl, dsep_datapath and dual_serial_eeprom_port_core.
package dsep_pkg;

   localparam int WORDS_PER_CHIP = 128;
   localparam int CHIP_COUNT     = 2;
   localparam int STORE_DEPTH    = WORDS_PER_CHIP * CHIP_COUNT;
   localparam int ADDR_W         = $clog2(WORDS_PER_CHIP);
   localparam int IDX_W          = $clog2(STORE_DEPTH);
   localparam int WORD_W         = 16;
   localparam int BIT_W          = $clog2(WORD_W);
   localparam int COUNT_W        = $clog2(STORE_DEPTH + 1);
   localparam int CODE_W         = 7;

   // The command code is taken from bits 14..8 of the word and inverted.
   localparam logic [CODE_W-1:0] CMD_INVERT  = 7'h7F;
   localparam logic [CODE_W-1:0] CMD_READ    = 7'h01;
   localparam logic [CODE_W-1:0] CMD_WRITE   = 7'h06;
   localparam logic [CODE_W-1:0] CMD_ERASE   = 7'h0C;
   localparam logic [CODE_W-1:0] CMD_ENABLE  = 7'h09;
   localparam logic [CODE_W-1:0] CMD_DISABLE = 7'h0B;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic finish;
   } ctrl_cmd_type;

endpackage

@@ hw/rtl/dual_serial_eeprom_port_core.sv @@
// Top level of the dual serial EEPROM port core.
// Joins the controller dsep_ctrl and the datapath dsep_datapath; depends on dsep_pkg.
//
//   channel   handshake             payload
//   request   start, busy           req_mode, req_port, req_write_value
//   result    rsp_strobe            rsp_read_value, rsp_modified
//
// A request is taken when start is high and busy is low. Its result is shown
// on the rsp ports after execute, finish and the result register, and is taken
// at the edge that ends the cycle in which it is shown; busy is high in execute
// and finish, which are set by the registered read of the word store. A new
// request can be taken in the cycle the result is shown, but not while the last
// one is in execute or finish. Reset is synchronous and clears the store through
// its nonzero flags at once. The receiver cannot stall.
module dual_serial_eeprom_port_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_mode,
   input  logic       req_port,
   input  logic [7:0] req_write_value,
   output logic       rsp_strobe,
   output logic [7:0] rsp_read_value,
   output logic       rsp_modified
);
   import dsep_pkg::*;

   ctrl_cmd_type cmd;

   dsep_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   dsep_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_mode        (req_mode),
      .req_port        (req_port),
      .req_write_value (req_write_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_read_value  (rsp_read_value),
      .rsp_modified    (rsp_modified)
   );

`ifndef ASSERT_OFF
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_strobe)
      else $error("result did not follow its request after three cycles");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after a request was taken");

   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && !$past(rsp_strobe)))
      else $error("result shown while busy or on two cycles in a row");

   a_read_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_read_value[7:5] == 3'b000 && rsp_read_value[2:0] == 3'b000))
      else $error("result carries bits outside phase and data");
`endif

endmodule

@@ hw/rtl/dsep_ctrl.sv @@
// Controller state machine of the dual serial EEPROM port core.
// Sequences each request through capture, execute and finish; depends on dsep_pkg.
module dsep_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output dsep_pkg::ctrl_cmd_type cmd
);
   import dsep_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ hw/rtl/dsep_datapath.sv @@
// Datapath of the dual serial EEPROM port core: serial assembly, command decode,
// word store with nonzero flags, and the result register; depends on dsep_pkg.
module dsep_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  dsep_pkg::ctrl_cmd_type cmd,
   input  logic                   req_mode,
   input  logic                   req_port,
   input  logic [7:0]             req_write_value,
   output logic                   rsp_strobe,
   output logic [7:0]             rsp_read_value,
   output logic                   rsp_modified
);
   import dsep_pkg::*;

   // Captured request
   logic req_mode_ff, req_port_ff, req_clk_ff;

   // Port state
   logic              last_clk_ff, last_clk_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              cs_ff, cs_in;
   logic              phase_ff, phase_in;
   logic              wen_ff, wen_in;
   logic [BIT_W-1:0]  bitcnt_ff, bitcnt_in;
   logic [WORD_W-1:0] shift_ff, shift_in;
   logic              wpend_ff, wpend_in;
   logic              ractive_ff, ractive_in;
   logic              modified_ff, modified_in;
   logic [COUNT_W-1:0] nzcount_ff, nzcount_in;

   // Store: a word whose flag is clear reads as zero.
   logic [WORD_W-1:0]      mem_ff [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] nz_ff;
   logic [WORD_W-1:0]      rd_word_ff;
   logic                   rd_nz_ff;

   // Handoff from execute to finish
   logic              commit_ff, commit_in;
   logic [WORD_W-1:0] commit_word_ff;
   logic [IDX_W-1:0]  commit_idx_ff;
   logic              rsp_phase_ff, rsp_phase_in;
   logic              rsp_den_ff, rsp_den_in;
   logic [BIT_W-1:0]  bitsel_ff, bitsel_in;

   // Result registers
   logic       rsp_strobe_ff;
   logic [7:0] rsp_read_value_ff, rsp_read_value_in;
   logic       rsp_modified_ff;

   logic              rise;
   logic [WORD_W-1:0] shifted;
   logic [CODE_W-1:0] code;
   logic [IDX_W-1:0]  mem_addr;
   logic              erase;
   logic [WORD_W-1:0] old_word;
   logic              change;
   logic              new_nz;
   logic              rd_bit;

   assign rise     = req_mode_ff & ~last_clk_ff & req_clk_ff;
   assign shifted  = shift_ff | ({{(WORD_W-1){1'b0}}, phase_ff} << bitcnt_ff);
   assign code     = shifted[14:8] ^ CMD_INVERT;
   assign mem_addr = {cs_in, addr_ff};
   assign old_word = rd_nz_ff ? rd_word_ff : '0;
   assign change   = cmd.finish & commit_ff & (old_word != commit_word_ff);
   assign new_nz   = |commit_word_ff;
   assign rd_bit   = rd_nz_ff & rd_word_ff[bitsel_ff];

   always_comb begin
      last_clk_in  = last_clk_ff;
      addr_in      = addr_ff;
      cs_in        = cs_ff;
      phase_in     = phase_ff;
      wen_in       = wen_ff;
      bitcnt_in    = bitcnt_ff;
      shift_in     = shift_ff;
      wpend_in     = wpend_ff;
      ractive_in   = ractive_ff;
      modified_in  = modified_ff;
      nzcount_in   = nzcount_ff;
      commit_in    = commit_ff;
      rsp_phase_in = rsp_phase_ff;
      rsp_den_in   = rsp_den_ff;
      bitsel_in    = bitsel_ff;
      erase        = 1'b0;
      rsp_read_value_in = {3'b000, rsp_phase_ff, rsp_den_ff & rd_bit, 3'b000};

      if (cmd.exec) begin
         commit_in    = 1'b0;
         rsp_phase_in = 1'b0;
         rsp_den_in   = 1'b0;
         bitsel_in    = bitcnt_ff;
         if (req_mode_ff) begin
            last_clk_in = req_clk_ff;
            if (rise) begin
               if (bitcnt_ff == BIT_W'(WORD_W - 1)) begin
                  bitcnt_in = '0;
                  shift_in  = '0;
                  if (wpend_ff) begin
                     wpend_in  = 1'b0;
                     commit_in = 1'b1;
                  end else begin
                     ractive_in = 1'b0;
                     unique case (code)
                        CMD_READ: begin
                           addr_in    = shifted[ADDR_W-1:0];
                           ractive_in = 1'b1;
                        end
                        CMD_WRITE: begin
                           if (wen_ff) begin
                              addr_in  = shifted[ADDR_W-1:0];
                              wpend_in = 1'b1;
                           end
                        end
                        CMD_ERASE: begin
                           if (wen_ff) begin
                              erase       = 1'b1;
                              modified_in = modified_ff | (nzcount_ff != '0);
                              nzcount_in  = '0;
                           end
                        end
                        CMD_ENABLE:  wen_in = 1'b1;
                        CMD_DISABLE: wen_in = 1'b0;
                        default: begin
                        end
                     endcase
                  end
               end else begin
                  bitcnt_in = bitcnt_ff + BIT_W'(1);
                  shift_in  = shifted;
               end
            end
         end else if (req_port_ff) begin
            // A high clock bit toggles chip select and restarts the assembly.
            if (last_clk_ff) begin
               cs_in     = ~cs_ff;
               shift_in  = '0;
               bitcnt_in = '0;
               bitsel_in = '0;
            end
            phase_in     = ~phase_ff;
            rsp_phase_in = ~phase_ff;
            rsp_den_in   = ractive_ff;
         end
      end else if (cmd.finish) begin
         if (change) begin
            modified_in = 1'b1;
            if (new_nz && !rd_nz_ff) begin
               nzcount_in = nzcount_ff + COUNT_W'(1);
            end else if (!new_nz && rd_nz_ff) begin
               nzcount_in = nzcount_ff - COUNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_clk_ff     <= 1'b0;
         addr_ff         <= '0;
         cs_ff           <= 1'b0;
         phase_ff        <= 1'b0;
         wen_ff          <= 1'b0;
         bitcnt_ff       <= '0;
         shift_ff        <= '0;
         wpend_ff        <= 1'b0;
         ractive_ff      <= 1'b0;
         modified_ff     <= 1'b0;
         nzcount_ff      <= '0;
         commit_ff       <= 1'b0;
         rsp_phase_ff    <= 1'b0;
         rsp_den_ff      <= 1'b0;
         bitsel_ff       <= '0;
         rsp_strobe_ff   <= 1'b0;
         rsp_modified_ff <= 1'b0;
      end else begin
         last_clk_ff   <= last_clk_in;
         addr_ff       <= addr_in;
         cs_ff         <= cs_in;
         phase_ff      <= phase_in;
         wen_ff        <= wen_in;
         bitcnt_ff     <= bitcnt_in;
         shift_ff      <= shift_in;
         wpend_ff      <= wpend_in;
         ractive_ff    <= ractive_in;
         modified_ff   <= modified_in;
         nzcount_ff    <= nzcount_in;
         commit_ff     <= commit_in;
         rsp_phase_ff  <= rsp_phase_in;
         rsp_den_ff    <= rsp_den_in;
         bitsel_ff     <= bitsel_in;
         rsp_strobe_ff <= cmd.finish;
         if (cmd.finish) begin
            rsp_modified_ff <= modified_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_mode_ff <= req_mode;
         req_port_ff <= req_port;
         req_clk_ff  <= req_write_value[0];
      end
      if (cmd.exec) begin
         commit_word_ff <= shifted;
         commit_idx_ff  <= mem_addr;
      end
      if (cmd.finish) begin
         rsp_read_value_ff <= rsp_read_value_in;
      end
   end

   // Word store: read while executing, written when finishing a pending write that changes the word.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rd_word_ff <= mem_ff[mem_addr];
      end
      if (change) begin
         mem_ff[commit_idx_ff] <= commit_word_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nz_ff    <= '0;
         rd_nz_ff <= 1'b0;
      end else begin
         if (cmd.exec) begin
            rd_nz_ff <= nz_ff[mem_addr];
         end
         if (erase) begin
            nz_ff <= '0;
         end else if (change) begin
            nz_ff[commit_idx_ff] <= new_nz;
         end
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_modified   = rsp_modified_ff;

endmodule

@@ tb/dual_serial_eeprom_port_core_test.sv @@
// Self-checking testbench for dual_serial_eeprom_port_core.
// Drives port accesses that build serial EEPROM commands, with random and abandoned ones, and predicts every reply.
// Depends on dsep_pkg and the dual_serial_eeprom_port_core RTL.
module dual_serial_eeprom_port_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import dsep_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;

   class eeprom_port_scoreboard;
      typedef struct packed {
         logic [7:0] read_value;
         logic       modified;
      } eeprom_reply_type;

      eeprom_reply_type expected_replies[$];
      int unsigned   errors;
      int unsigned   request_count;

      logic          clock_level;
      logic [6:0]    word_addr;
      logic          chip_sel;
      logic          phase;
      logic          wr_enable;
      logic [3:0]    bit_count;
      logic [15:0]   shift_reg;
      logic          write_armed;
      logic          read_armed;
      logic          modified;
      logic [15:0]   rom_words[STORE_DEPTH];

      function void clear_state();
         clock_level = 1'b0;
         word_addr   = '0;
         chip_sel    = 1'b0;
         phase       = 1'b0;
         wr_enable   = 1'b0;
         bit_count   = '0;
         shift_reg   = '0;
         write_armed = 1'b0;
         read_armed  = 1'b0;
         modified    = 1'b0;
         foreach (rom_words[i]) rom_words[i] = '0;
      endfunction

      // A finished 16-bit word either completes a pending write or is decoded.
      function void apply_word(logic [15:0] w);
         logic [6:0] code;
         if (write_armed) begin
            if (rom_words[{chip_sel, word_addr}] != w) begin
               rom_words[{chip_sel, word_addr}] = w;
               modified = 1'b1;
            end
            write_armed = 1'b0;
            return;
         end
         read_armed = 1'b0;
         code = w[14:8] ^ CMD_INVERT;
         case (code)
            CMD_READ: begin
               word_addr  = w[6:0];
               read_armed = 1'b1;
            end
            CMD_WRITE: begin
               if (wr_enable) begin
                  word_addr   = w[6:0];
                  write_armed = 1'b1;
               end
            end
            CMD_ERASE: begin
               if (wr_enable) begin
                  foreach (rom_words[i]) begin
                     if (rom_words[i] != '0) modified = 1'b1;
                     rom_words[i] = '0;
                  end
               end
            end
            CMD_ENABLE:  wr_enable = 1'b1;
            CMD_DISABLE: wr_enable = 1'b0;
            default: ;
         endcase
      endfunction

      function void note_access(logic mode, logic port, logic [7:0] value);
         eeprom_reply_type reply;
         reply = '0;
         if (mode) begin
            if (!clock_level && value[0]) begin
               if (phase) shift_reg[bit_count] = 1'b1;
               if (bit_count == 4'd15) begin
                  apply_word(shift_reg);
                  bit_count = '0;
                  shift_reg = '0;
               end else begin
                  bit_count = bit_count + 4'd1;
               end
            end
            clock_level = value[0];
         end else if (port) begin
            // A read with the serial clock high toggles chip select first.
            if (clock_level) begin
               chip_sel  = ~chip_sel;
               shift_reg = '0;
               bit_count = '0;
            end
            phase = ~phase;
            reply.read_value[4] = phase;
            if (read_armed) reply.read_value[3] = rom_words[{chip_sel, word_addr}][bit_count];
         end
         reply.modified = modified;
         expected_replies.push_back(reply);
         request_count++;
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("mismatch: %s got 0x%0h expected 0x%0h (request %0d pending %0d)",
                  what, got, want, request_count, expected_replies.size());
         errors++;
      endtask

      task check_reply(logic [7:0] read_value, logic modified_bit);
         eeprom_reply_type want;
         if (expected_replies.size() == 0) begin
            report_mismatch("unexpected reply read_value", int'(read_value), 0);
            return;
         end
         want = expected_replies.pop_front();
         if (read_value !== want.read_value)
            report_mismatch("read_value", int'(read_value), int'(want.read_value));
         if (modified_bit !== want.modified)
            report_mismatch("modified", int'(modified_bit), int'(want.modified));
      endtask
   endclass

   logic       clock;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic       req_mode = 1'b0;
   logic       req_port = 1'b0;
   logic [7:0] req_write_value = '0;
   logic       rsp_strobe;
   logic [7:0] rsp_read_value;
   logic       rsp_modified;

   eeprom_port_scoreboard board = new;

   // Stimulus side view of the few state bits that shape the sequences.
   logic        gen_clock = 1'b0;
   logic        gen_phase = 1'b0;
   logic        gen_chip  = 1'b0;
   int unsigned sender_idle_pct = 0;
   int unsigned items_sent = 0;
   int unsigned quiet_cycles = 0;

   dual_serial_eeprom_port_core DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_port       (req_port),
      .req_write_value(req_write_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_read_value (rsp_read_value),
      .rsp_modified   (rsp_modified)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) board.check_reply(rsp_read_value, rsp_modified);
         if (start && !busy) board.note_access(req_mode, req_port, req_write_value);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Start stays high across back-to-back requests and drops only for an idle gap.
   task automatic send_request(input logic mode, input logic port, input logic [7:0] value);
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_mode        <= mode;
      req_port        <= port;
      req_write_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (mode) begin
         gen_clock = value[0];
      end else if (port) begin
         if (gen_clock) gen_chip = ~gen_chip;
         gen_phase = ~gen_phase;
      end
      items_sent++;
   endtask

   task automatic clock_write(input logic level);
      send_request(1'b1, 1'($urandom_range(1)), {7'($urandom), level});
   endtask

   task automatic port_read();
      send_request(1'b0, 1'b1, 8'($urandom));
   endtask

   // Clears the bit assembly by toggling chip select and leaves the chosen chip selected.
   task automatic sync_chip(input logic chip);
      clock_write(1'b1);
      port_read();
      if (gen_chip != chip) port_read();
      clock_write(1'b0);
   endtask

   // Each data bit is the output phase at the clock's rising edge, so the
   // phase is flipped with a low-clock read whenever it disagrees.
   task automatic shift_bits(input logic [15:0] w, input int count);
      if (gen_clock) clock_write(1'b0);
      for (int i = 0; i < count; i++) begin
         if (gen_phase != w[i]) port_read();
         clock_write(1'b1);
         clock_write(1'b0);
      end
   endtask

   task automatic issue_command(input logic chip, input logic [6:0] code,
                                input logic [6:0] addr);
      logic [15:0] word;
      word = {1'($urandom), code ^ CMD_INVERT, 1'($urandom), addr};
      sync_chip(chip);
      shift_bits(word, 16);
   endtask

   task automatic store_word(input logic chip, input logic [6:0] addr, input logic [15:0] data);
      issue_command(chip, CMD_WRITE, addr);
      // The pending write lands on whichever chip is selected when the data completes.
      if ($urandom_range(3) == 0) sync_chip(1'($urandom_range(1)));
      shift_bits(data, 16);
   endtask

   task automatic fetch_word(input logic chip, input logic [6:0] addr);
      issue_command(chip, CMD_READ, addr);
      repeat ($urandom_range(10, 24)) begin
         if ($urandom_range(1)) begin
            port_read();
         end else begin
            clock_write(1'b1);
            clock_write(1'b0);
         end
      end
   endtask

   function automatic logic [6:0] pick_address();
      logic [6:0] hot_addrs[4];
      hot_addrs = '{7'd0, 7'd127, 7'd5, 7'd64};
      if ($urandom_range(1)) return hot_addrs[$urandom_range(3)];
      return 7'($urandom_range(127));
   endfunction

   task automatic run_random_sequence(inout logic [15:0] last_data);
      int         pick;
      logic       chip;
      logic [6:0] addr;
      logic [15:0] data;
      pick = $urandom_range(99);
      chip = 1'($urandom_range(1));
      addr = pick_address();
      if (pick < 10) begin
         issue_command(chip, CMD_ENABLE, addr);
      end else if (pick < 14) begin
         issue_command(chip, CMD_DISABLE, addr);
      end else if (pick < 44) begin
         case ($urandom_range(3))
            0: data = '0;
            1: data = '1;
            2: data = last_data;
            default: data = 16'($urandom);
         endcase
         last_data = data;
         if ($urandom_range(9) < 7) issue_command(chip, CMD_ENABLE, addr);
         store_word(chip, addr, data);
      end else if (pick < 70) begin
         fetch_word(chip, addr);
      end else if (pick < 74) begin
         issue_command(chip, CMD_ENABLE, addr);
         issue_command(chip, CMD_ERASE, addr);
      end else if (pick < 80) begin
         sync_chip(chip);
         shift_bits(16'($urandom), 16);
      end else if (pick < 90) begin
         repeat ($urandom_range(1, 6))
            send_request(1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom));
      end else begin
         // Abandoned word: a chip select toggle in the middle of the assembly.
         sync_chip(chip);
         shift_bits(16'($urandom), $urandom_range(1, 15));
         sync_chip(1'($urandom_range(1)));
      end
   endtask

   initial begin
      logic [15:0] last_data;
      last_data = 16'h1234;
      board.clear_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Field extremes: port 0 reads, clock edges with busy upper bits, reads with clock high.
      sender_idle_pct = 8;
      send_request(1'b0, 1'b0, 8'h00);
      send_request(1'b0, 1'b0, 8'hFF);
      send_request(1'b0, 1'b1, 8'hFF);
      send_request(1'b0, 1'b1, 8'h00);
      send_request(1'b1, 1'b1, 8'hFE);
      send_request(1'b1, 1'b0, 8'h01);
      send_request(1'b1, 1'b1, 8'hFF);
      send_request(1'b0, 1'b0, 8'hAA);
      send_request(1'b0, 1'b1, 8'h55);
      send_request(1'b1, 1'b0, 8'h00);
      send_request(1'b1, 1'b1, 8'h81);
      send_request(1'b0, 1'b1, 8'h7E);
      send_request(1'b1, 1'b0, 8'hFE);

      // Command coverage with a disabled store first, then the unchanged-write case.
      store_word(1'b0, 7'd0, 16'h0000);
      issue_command(1'b0, CMD_ENABLE, 7'd0);
      store_word(1'b0, 7'd0, 16'h0000);
      fetch_word(1'b0, 7'd0);
      store_word(1'b1, 7'd127, 16'hFFFF);
      fetch_word(1'b1, 7'd127);
      issue_command(1'b0, CMD_ERASE, 7'd0);
      fetch_word(1'b1, 7'd127);
      issue_command(1'b1, CMD_DISABLE, 7'd127);
      issue_command(1'b0, CMD_ERASE, 7'd0);
      sync_chip(1'b1);
      shift_bits(16'($urandom), 16);

      while (items_sent < 300) run_random_sequence(last_data);
      sender_idle_pct = 74;
      while (items_sent < 560) run_random_sequence(last_data);
      sender_idle_pct = 0;
      while (items_sent < 820) run_random_sequence(last_data);
      start <= 1'b0;

      while (board.expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.expected_replies.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
